FILE: hdl/pfa_pkg.sv
// Shared types and constants for the pixel format to ARGB32 converter.
`default_nettype none

package pfa_pkg;

	// Source format codes; codes above MRGB32 convert as ARGB32.
	typedef enum logic [3:0] {
		FMT_MONO   = 4'd0,
		FMT_MASK   = 4'd1,
		FMT_RGBX   = 4'd2,
		FMT_RGB    = 4'd3,
		FMT_RGBA   = 4'd4,
		FMT_RGB32  = 4'd5,
		FMT_ARGB32 = 4'd6,
		FMT_RGBM   = 4'd7,
		FMT_MRGB32 = 4'd8
	} src_fmt_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SOURCE_FORMAT = 2'd0,
		REG_MASK_RED      = 2'd1,
		REG_MASK_GREEN    = 2'd2,
		REG_MASK_BLUE     = 2'd3
	} reg_idx_t;

	localparam logic [7:0] OPAQUE_ALPHA = 8'hff;

	typedef struct packed {
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
		logic       line_end_in;
	} pixel_in_t;

	typedef struct packed {
		logic [31:0] argb_pixel;
		logic        line_end_out;
	} pixel_out_t;

	typedef struct packed {
		logic [3:0] source_format;
		logic [7:0] mask_red;
		logic [7:0] mask_green;
		logic [7:0] mask_blue;
	} cfg_t;

endpackage

`default_nettype wire

FILE: hdl/pfa_cfg_regs.sv
// Configuration register file of the pixel format converter.
`default_nettype none

module pfa_cfg_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire pfa_pkg::reg_idx_t wr_index,
	input  wire logic [7:0]        wr_data,
	output pfa_pkg::cfg_t          cfg
);

	pfa_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_format <= pfa_pkg::FMT_ARGB32;
			cfg_q.mask_red      <= 8'd0;
			cfg_q.mask_green    <= 8'd0;
			cfg_q.mask_blue     <= 8'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				pfa_pkg::REG_SOURCE_FORMAT: cfg_q.source_format <= wr_data[3:0];
				pfa_pkg::REG_MASK_RED:      cfg_q.mask_red      <= wr_data;
				pfa_pkg::REG_MASK_GREEN:    cfg_q.mask_green    <= wr_data;
				pfa_pkg::REG_MASK_BLUE:     cfg_q.mask_blue     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/pfa_convert.sv
// Combinational conversion of one source pixel into an ARGB32 word.
`default_nettype none

module pfa_convert (
	input  wire pfa_pkg::cfg_t      cfg,
	input  wire pfa_pkg::pixel_in_t pix_in,
	output pfa_pkg::pixel_out_t     pix_out
);

	logic [7:0]  b0, b1, b2, b3;
	logic [7:0]  scale_a, col_r, col_g, col_b;
	logic [15:0] prod_r, prod_g, prod_b;
	logic [31:0] word;

	assign b0   = pix_in.byte_zero;
	assign b1   = pix_in.byte_one;
	assign b2   = pix_in.byte_two;
	assign b3   = pix_in.byte_three;
	assign word = {b3, b2, b1, b0};

	// Pick the scaling operands; only mask, rgbm and mrgb32 use the products.
	always_comb begin
		scale_a = b3;
		col_r   = b0;
		col_g   = b1;
		col_b   = b2;
		if (cfg.source_format == pfa_pkg::FMT_MASK) begin
			scale_a = pfa_pkg::OPAQUE_ALPHA - b0;
			col_r   = cfg.mask_red;
			col_g   = cfg.mask_green;
			col_b   = cfg.mask_blue;
		end else if (cfg.source_format == pfa_pkg::FMT_MRGB32) begin
			col_r = b2;
			col_b = b0;
		end
	end

	assign prod_r = col_r * scale_a;
	assign prod_g = col_g * scale_a;
	assign prod_b = col_b * scale_a;

	always_comb begin
		pix_out.line_end_out = pix_in.line_end_in;
		unique case (cfg.source_format)
			pfa_pkg::FMT_MONO:
				pix_out.argb_pixel = {pfa_pkg::OPAQUE_ALPHA, b0, b0, b0};
			pfa_pkg::FMT_RGBX, pfa_pkg::FMT_RGB:
				pix_out.argb_pixel = {pfa_pkg::OPAQUE_ALPHA, b0, b1, b2};
			pfa_pkg::FMT_RGBA:
				pix_out.argb_pixel = {b3, b0, b1, b2};
			pfa_pkg::FMT_MASK, pfa_pkg::FMT_RGBM, pfa_pkg::FMT_MRGB32:
				pix_out.argb_pixel = {scale_a, prod_r[15:8], prod_g[15:8], prod_b[15:8]};
			default:
				pix_out.argb_pixel = word;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/pixel_format_to_argb32.sv
// Top level of the pixel format to ARGB32 converter.
//
// Channels: src_* carries one source pixel (four bytes in memory order plus
// a line-end flag) per transaction; dst_* carries the ARGB32 result and the
// copied flag. Both use valid/ready. cfg_* writes one configuration register
// per transaction (index 0 source format, 1..3 mask red/green/blue); it is
// always ready and must only be used while no pixel is in flight.
// Path: a pixel accepted at a clock edge lands in the input register at
// that edge, is converted combinationally and is then registered into the
// result register, from which it is presented on dst.
// Throughput: one pixel per cycle while dst_ready is high; the three 8x8
// channel multipliers sit between the input and result registers.
// Stall: when dst_ready is low the result holds and the input register still
// takes one more pixel; src_ready drops only when both stages are full.
// Reset: arst_n clears both stage valids and loads the format register with
// ARGB32 and the mask colour with black.
`default_nettype none

module pixel_format_to_argb32 (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_valid,
	output logic                    src_ready,
	input  wire pfa_pkg::pixel_in_t src_data,
	output logic                    dst_valid,
	input  wire logic               dst_ready,
	output pfa_pkg::pixel_out_t     dst_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);

	pfa_pkg::cfg_t       cfg;
	pfa_pkg::pixel_in_t  data_s1;
	pfa_pkg::pixel_out_t conv;
	pfa_pkg::pixel_out_t data_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic                adv_s2;

	assign cfg_ready = 1'b1;

	pfa_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (pfa_pkg::reg_idx_t'(cfg_index)),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Result register takes a new pixel when empty or being drained.
	assign adv_s2    = !valid_s2 || dst_ready;
	// Input register takes a new pixel when empty or moving on.
	assign src_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	// Payload needs no reset; load it whenever a transaction enters.
	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			data_s1 <= src_data;
		end
	end

	pfa_convert u_convert (
		.cfg     (cfg),
		.pix_in  (data_s1),
		.pix_out (conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			data_s2 <= conv;
		end
	end

	assign dst_valid = valid_s2;
	assign dst_data  = data_s2;

	// Backpressure only when both stages are full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> (valid_s1 && valid_s2))
		else $error("src_ready low while a stage is empty");

	// An accepted transaction lands in the input register.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready) |=> valid_s1)
		else $error("accepted pixel lost before input register");

	// A blocked input register holds its pixel.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(data_s1)))
		else $error("input register changed while blocked");

	// The line-end flag moves with its pixel into the result register.
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=>
		(dst_valid && (dst_data.line_end_out == $past(data_s1.line_end_in))))
		else $error("line-end flag mismatch at result register");

endmodule

`default_nettype wire

FILE: sim/pixel_format_to_argb32_tb.sv
// Self-checking testbench for the pixel format to ARGB32 converter.
module pixel_format_to_argb32_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Two pipeline stages inside the block; the settle wait adds spare margin.
	localparam int PIPE_SETTLE   = 6;
	// Cycles without any transaction on any channel before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 2000;
	// Length of the long receiver hold-off in the back-pressure test.
	localparam int HOLD_LEN      = 60;
	localparam int PHASE_ITEMS   = 320;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_ready;
	pfa_pkg::pixel_in_t  src_data = '0;
	logic                dst_valid;
	logic                dst_ready = 1'b0;
	pfa_pkg::pixel_out_t dst_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = pfa_pkg::REG_SOURCE_FORMAT;
	logic [7:0]          cfg_data = '0;

	// Shadow of the configuration registers as the block should hold them.
	pfa_pkg::cfg_t       cfg_shadow;
	// Converted pixels still owed by the block, oldest first.
	pfa_pkg::pixel_out_t pending_argb[$];

	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int src_idle_pct   = 0;
	int dst_stall_pct  = 0;
	int dst_hold_left  = 0;

	pixel_format_to_argb32 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Scale an 8-bit channel by an 8-bit alpha, keeping the upper byte of the product.
	function automatic logic [7:0] premultiply(input logic [7:0] chan, input logic [7:0] alpha);
		logic [15:0] prod;
		prod = chan * alpha;
		return prod[15:8];
	endfunction

	// Expected ARGB32 word and line-end flag for one source pixel.
	function automatic pfa_pkg::pixel_out_t convert_to_argb(input pfa_pkg::pixel_in_t px,
		input pfa_pkg::cfg_t c);
		pfa_pkg::pixel_out_t res;
		logic [7:0] alpha;
		res.line_end_out = px.line_end_in;
		case (c.source_format)
			pfa_pkg::FMT_MONO: begin
				res.argb_pixel = {pfa_pkg::OPAQUE_ALPHA, px.byte_zero, px.byte_zero,
					px.byte_zero};
			end
			pfa_pkg::FMT_MASK: begin
				// Mask byte is coverage inverted; the mask colour is scaled by it.
				alpha = pfa_pkg::OPAQUE_ALPHA - px.byte_zero;
				res.argb_pixel = {alpha, premultiply(c.mask_red, alpha),
					premultiply(c.mask_green, alpha), premultiply(c.mask_blue, alpha)};
			end
			pfa_pkg::FMT_RGBX, pfa_pkg::FMT_RGB: begin
				res.argb_pixel = {pfa_pkg::OPAQUE_ALPHA, px.byte_zero, px.byte_one,
					px.byte_two};
			end
			pfa_pkg::FMT_RGBA: begin
				res.argb_pixel = {px.byte_three, px.byte_zero, px.byte_one, px.byte_two};
			end
			pfa_pkg::FMT_RGBM: begin
				res.argb_pixel = {px.byte_three, premultiply(px.byte_zero, px.byte_three),
					premultiply(px.byte_one, px.byte_three),
					premultiply(px.byte_two, px.byte_three)};
			end
			pfa_pkg::FMT_MRGB32: begin
				// Little-endian word: byte two is red, byte zero is blue.
				res.argb_pixel = {px.byte_three, premultiply(px.byte_two, px.byte_three),
					premultiply(px.byte_one, px.byte_three),
					premultiply(px.byte_zero, px.byte_three)};
			end
			default: begin
				// RGB32, ARGB32 and every undefined code copy the word through.
				res.argb_pixel = {px.byte_three, px.byte_two, px.byte_one, px.byte_zero};
			end
		endcase
		return res;
	endfunction

	// Bias toward the channel extremes so both ends show up often.
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic pfa_pkg::pixel_in_t rand_pixel();
		return pfa_pkg::pixel_in_t'{rand_byte(), rand_byte(), rand_byte(), rand_byte(),
			($urandom_range(7) == 0)};
	endfunction

	// Write one register; leave cfg_valid high so a following write can reuse it.
	task automatic write_reg(input pfa_pkg::reg_idx_t idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pfa_pkg::REG_SOURCE_FORMAT: cfg_shadow.source_format = value[3:0];
			pfa_pkg::REG_MASK_RED:      cfg_shadow.mask_red      = value;
			pfa_pkg::REG_MASK_GREEN:    cfg_shadow.mask_green    = value;
			pfa_pkg::REG_MASK_BLUE:     cfg_shadow.mask_blue     = value;
		endcase
	endtask

	// Rewrite all four registers, then drop the write channel.
	task automatic set_config(input logic [7:0] fmt_word, input logic [7:0] red,
		input logic [7:0] green, input logic [7:0] blue);
		write_reg(pfa_pkg::REG_SOURCE_FORMAT, fmt_word);
		write_reg(pfa_pkg::REG_MASK_RED, red);
		write_reg(pfa_pkg::REG_MASK_GREEN, green);
		write_reg(pfa_pkg::REG_MASK_BLUE, blue);
		cfg_valid <= 1'b0;
	endtask

	// Offer one pixel, idling first at the current rate; valid stays up afterwards
	// so back-to-back pixels never see it dropped and raised in one step.
	task automatic send_pixel(input pfa_pkg::pixel_in_t px);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= px;
		@(posedge clk);
		while (!src_ready) @(posedge clk);
		pending_argb.push_back(convert_to_argb(px, cfg_shadow));
	endtask

	// Stop offering pixels and hold until every owed result has come out.
	task automatic wait_for_results();
		src_valid <= 1'b0;
		while (pending_argb.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// Reset defaults: ARGB32 copy-through, then mask mode with a black mask colour.
	task automatic test_reset_values();
		send_pixel(pfa_pkg::pixel_in_t'{8'h12, 8'h9a, 8'hc3, 8'h5e, 1'b1});
		send_pixel(pfa_pkg::pixel_in_t'{8'hff, 8'h00, 8'hff, 8'h00, 1'b0});
		wait_for_results();
		write_reg(pfa_pkg::REG_SOURCE_FORMAT, 8'(pfa_pkg::FMT_MASK));
		cfg_valid <= 1'b0;
		send_pixel(pfa_pkg::pixel_in_t'{8'h00, 8'h55, 8'haa, 8'hff, 1'b1});
		send_pixel(pfa_pkg::pixel_in_t'{8'h80, 8'h01, 8'h02, 8'h03, 1'b0});
		wait_for_results();
	endtask

	// Every defined format with all-ones bytes and with distinct bytes.
	task automatic test_each_format();
		for (int f = pfa_pkg::FMT_MONO; f <= pfa_pkg::FMT_MRGB32; f++) begin
			set_config(8'(f), 8'hff, 8'h00, 8'h81);
			send_pixel(pfa_pkg::pixel_in_t'{8'hff, 8'hff, 8'hff, 8'hff, 1'b1});
			send_pixel(pfa_pkg::pixel_in_t'{8'h12, 8'h9a, 8'hc3, 8'h5e, 1'b0});
			wait_for_results();
		end
	endtask

	// Codes above MRGB32 must behave as ARGB32.
	task automatic test_undefined_formats();
		for (int f = pfa_pkg::FMT_MRGB32 + 1; f <= 15; f++) begin
			set_config(8'(f), 8'h00, 8'hff, 8'h3c);
			send_pixel(pfa_pkg::pixel_in_t'{8'(f * 17), 8'h9a, 8'hc3, 8'h5e, f[0]});
			wait_for_results();
		end
	endtask

	// Random pixels under random configurations at one idling mix.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int sent;
		int burst;
		logic [3:0] fmt;
		src_idle_pct  = idle_pct;
		dst_stall_pct = stall_pct;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			// Mostly defined formats, sometimes any code; random upper nibble
			// checks that only the low four bits land in the register.
			fmt = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
				: 4'($urandom_range(pfa_pkg::FMT_MRGB32));
			set_config({4'($urandom_range(15)), fmt}, rand_byte(), rand_byte(), rand_byte());
			burst = $urandom_range(30, 90);
			repeat (burst) send_pixel(rand_pixel());
			sent += burst;
			wait_for_results();
		end
	endtask

	// Long receiver hold-off with the sender pushing until the block stalls,
	// then a sender pause until the pipeline is empty, then full rate again.
	task automatic test_backpressure();
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		set_config(8'(pfa_pkg::FMT_RGBM), rand_byte(), rand_byte(), rand_byte());
		dst_hold_left = HOLD_LEN;
		repeat (24) send_pixel(rand_pixel());
		wait_for_results();
		repeat (12) send_pixel(rand_pixel());
		wait_for_results();
	endtask

	// Receiver: honor a requested hold-off first, otherwise stall at the phase rate.
	always @(posedge clk) begin
		if (dst_hold_left > 0) begin
			dst_hold_left--;
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= ($urandom_range(99) >= dst_stall_pct);
		end
	end

	// Result checker and watchdog; samples see values from before the edge.
	always @(posedge clk) begin
		pfa_pkg::pixel_out_t want;
		if (arst_n) begin
			if (dst_valid && dst_ready) begin
				if (pending_argb.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected transaction: expected none, actual %h/%b",
						$time, dst_data.argb_pixel, dst_data.line_end_out);
				end else begin
					want = pending_argb.pop_front();
					if (dst_data.argb_pixel !== want.argb_pixel) begin
						mismatch_count++;
						$display("%0t: argb_pixel mismatch: expected %h, actual %h",
							$time, want.argb_pixel, dst_data.argb_pixel);
					end
					if (dst_data.line_end_out !== want.line_end_out) begin
						mismatch_count++;
						$display("%0t: line_end_out mismatch: expected %b, actual %b",
							$time, want.line_end_out, dst_data.line_end_out);
					end
				end
			end
			// Reset the quiet count on any transaction on any channel.
			if ((src_valid && src_ready) || (dst_valid && dst_ready)
				|| (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d results outstanding",
					$time, pending_argb.size());
				$display("pixel_format_to_argb32_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		cfg_shadow = '{source_format: pfa_pkg::FMT_ARGB32, mask_red: 8'h00,
			mask_green: 8'h00, mask_blue: 8'h00};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_each_format();
		test_undefined_formats();
		test_random_traffic(0, 0);
		test_random_traffic(73, 0);
		test_random_traffic(0, 73);
		test_random_traffic(33, 33);
		test_backpressure();

		wait_for_results();
		if (mismatch_count == 0) begin
			$display("pixel_format_to_argb32_tb: done, clean");
		end else begin
			$display("pixel_format_to_argb32_tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/pfa_pkg.sv
hdl/pfa_cfg_regs.sv
hdl/pfa_convert.sv
hdl/pixel_format_to_argb32.sv
sim/pixel_format_to_argb32_tb.sv
